// File: src/indexed_min_heap_decrease_key_assert.svh
// Assertion macros shared by the indexed min-heap RTL.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH

// Checks that cons holds in the same cycle as ante; uses clk and arst_n of the includer.
`define IMH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante.
`define IMH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/imh_pkg.sv
// Shared field widths, action codes and status codes of the indexed min-heap.
`timescale 1ns / 1ps

package imh_pkg;

	localparam int ACTION_W     = 2;
	localparam int NODE_FIELD_W = 8;
	localparam int KEY_FIELD_W  = 32;
	localparam int STATUS_W     = 3;
	localparam int COUNT_W      = 9;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_PAD_W  = OUT_DATA_W - (NODE_FIELD_W + KEY_FIELD_W + STATUS_W + COUNT_W);

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_DEC_KEY = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_FULL       = 3'd2,
		ST_QUEUED     = 3'd3,
		ST_NOT_QUEUED = 3'd4
	} status_t;

endpackage

// File: src/imh_cmp.sv
// Shared (key, node) priority comparator used by every sift step.
`timescale 1ns / 1ps

module imh_cmp #(
	parameter int KEY_W  = 32,
	parameter int NODE_W = 8
) (
	input  logic [KEY_W-1:0]  a_key,
	input  logic [NODE_W-1:0] a_node,
	input  logic [KEY_W-1:0]  b_key,
	input  logic [NODE_W-1:0] b_node,
	output logic              a_first
);

	// A smaller key wins; on equal keys the smaller node number wins.
	assign a_first = (a_key < b_key) || ((a_key == b_key) && (a_node < b_node));

endmodule

// File: src/indexed_min_heap_decrease_key.sv
// Top level of the indexed binary min-heap with push, pop, decrease-key and clear.
//
//   Channel   Dir  Handshake          Word contents (lowest bit first)
//   s_*       in   s_tvalid/s_tready  action[1:0], node[9:2], key[41:10]
//   m_*       out  m_tvalid/m_tready  popped_node[7:0], popped_key[39:8], status[42:40],
//                                     queued_count[51:43]
//
// One word is handled at a time by a small sequencer around a single comparator
// and three single-port-write memories (slot table, slot-of-node table, key table).
// Clear and words rejected on entry (full heap, pop of an empty heap) go straight to the
// result state; a push or decrease-key first passes the membership check, which may
// reject it, and then compares the node with one parent after another as it climbs,
// up to the root at most. A pop that empties the heap ends once the top is read; any
// other pop sifts the moved last node down level by level, and each level needs a slot
// read, a key read and two passes through the shared comparator.
// Reset only clears the sequencer, the heap size and the output valid; the tables
// are never cleared, since membership is derived from the slot tables and heap size.
// A finished result waits in the output register while the next word is taken; a
// result that cannot move into a still occupied output register holds the sequencer.
`timescale 1ns / 1ps
`include "indexed_min_heap_decrease_key_assert.svh"

module indexed_min_heap_decrease_key #(
	parameter int MAX_NODES = 256,
	parameter int KEY_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// action[1:0], node[9:2], key[41:10], zero pad above
	input  logic [imh_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// popped_node[7:0], popped_key[39:8], status[42:40], queued_count[51:43], zero pad above
	output logic [imh_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready
);

	import imh_pkg::*;

	// Slot and node indexes share one width; the size counter must also hold MAX_NODES.
	localparam int SLOT_W = $clog2(MAX_NODES);
	localparam int SIZE_W = $clog2(MAX_NODES + 1);
	localparam int IDX_W  = SIZE_W + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK0,
		S_CHK1,
		S_CHK2,
		S_UP0,
		S_UP1,
		S_UP2,
		S_POP0,
		S_POP1,
		S_POP2,
		S_DN0,
		S_DN1,
		S_DN2,
		S_DN3,
		S_DONE
	} state_t;

	// Input word fields.
	logic [ACTION_W-1:0]     in_action;
	logic [NODE_FIELD_W-1:0] in_node;
	logic [KEY_FIELD_W-1:0]  in_key;
	logic                    in_node_oob;
	logic                    in_accept;

	assign in_action   = s_tdata[ACTION_W-1:0];
	assign in_node     = s_tdata[ACTION_W+NODE_FIELD_W-1:ACTION_W];
	assign in_key      = s_tdata[ACTION_W+NODE_FIELD_W+KEY_FIELD_W-1:ACTION_W+NODE_FIELD_W];
	assign in_node_oob = 32'(in_node) >= 32'(MAX_NODES);

	// Sequencer and working registers.
	state_t              state_q;
	action_t             act_q;
	logic [SLOT_W-1:0]   node_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SLOT_W-1:0]   mov_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [SIZE_W-1:0]   size_q;
	status_t             status_q;
	logic [NODE_FIELD_W-1:0] pop_node_q;
	logic [KEY_FIELD_W-1:0]  pop_key_q;
	logic [SLOT_W-1:0]   par_q;
	logic [SLOT_W-1:0]   lch_q;
	logic [SLOT_W-1:0]   rch_q;
	logic [SLOT_W-1:0]   ch_node_q;
	logic [KEY_BITS-1:0] ch_key_q;
	logic [SLOT_W-1:0]   ch_slot_q;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// Memories and their registered read data.
	logic [SLOT_W-1:0]   hs_mem  [MAX_NODES];
	logic [SLOT_W-1:0]   son_mem [MAX_NODES];
	logic [KEY_BITS-1:0] key_mem [MAX_NODES];
	logic [SLOT_W-1:0]   hs_rd_a_q;
	logic [SLOT_W-1:0]   hs_rd_b_q;
	logic [SLOT_W-1:0]   son_rd_q;
	logic [KEY_BITS-1:0] key_rd_a_q;
	logic [KEY_BITS-1:0] key_rd_b_q;

	// Address, placement and comparator control.
	logic [SLOT_W-1:0]   hs_ra_a;
	logic [SLOT_W-1:0]   hs_ra_b;
	logic                place_we;
	logic [SLOT_W-1:0]   place_slot;
	logic [SLOT_W-1:0]   place_node;
	logic                key_we;
	logic                chk_queued;
	logic [SLOT_W-1:0]   parent_slot;
	logic [SLOT_W-1:0]   grand_slot;
	logic [IDX_W-1:0]    left_idx;
	logic [IDX_W-1:0]    right_idx;
	logic                l_ok;
	logic                r_ok;
	logic [KEY_BITS-1:0] cmp_a_key;
	logic [SLOT_W-1:0]   cmp_a_node;
	logic [KEY_BITS-1:0] cmp_b_key;
	logic [SLOT_W-1:0]   cmp_b_node;
	logic                cmp_a_first;
	logic                out_load;

	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_load  = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// Tree navigation around the current hole position.
	assign parent_slot = (pos_q - SLOT_W'(1)) >> 1;
	assign grand_slot  = (parent_slot - SLOT_W'(1)) >> 1;
	assign left_idx    = (IDX_W'(pos_q) << 1) + IDX_W'(1);
	assign right_idx   = (IDX_W'(pos_q) << 1) + IDX_W'(2);
	assign l_ok        = left_idx < IDX_W'(size_q);
	assign r_ok        = right_idx < IDX_W'(size_q);

	// A node is queued exactly when its recorded slot lies inside the heap and that
	// slot holds the node back. Written with an if so that a never-written table
	// entry reads as not queued.
	always_comb begin
		chk_queued = 1'b0;
		if ((IDX_W'(pos_q) < IDX_W'(size_q)) && (hs_rd_a_q == node_q)) begin
			chk_queued = 1'b1;
		end
	end

	always_comb begin
		key_we = 1'b0;
		if (state_q == S_CHK2) begin
			if (act_q == ACT_PUSH) begin
				key_we = !chk_queued;
			end else begin
				key_we = chk_queued;
			end
		end
	end

	// Slot table read addresses for each step.
	always_comb begin
		hs_ra_a = '0;
		hs_ra_b = '0;
		case (state_q)
			S_CHK1: hs_ra_a = son_rd_q;
			S_UP0:  hs_ra_a = parent_slot;
			S_UP2:  hs_ra_a = grand_slot;
			S_POP0: hs_ra_b = SLOT_W'(size_q - SIZE_W'(1));
			S_DN0: begin
				hs_ra_a = SLOT_W'(left_idx);
				hs_ra_b = r_ok ? SLOT_W'(right_idx) : SLOT_W'(left_idx);
			end
			default: ;
		endcase
	end

	// The sift keeps the moving node in registers and only writes a node into a slot
	// when it is settled there; every placement updates both slot tables together.
	always_comb begin
		place_we   = 1'b0;
		place_slot = pos_q;
		place_node = mov_q;
		case (state_q)
			S_UP0: place_we = (pos_q == '0);
			S_UP2: begin
				place_we = 1'b1;
				if (cmp_a_first) begin
					place_node = par_q;
				end
			end
			S_DN0: place_we = !l_ok;
			S_DN3: begin
				place_we = 1'b1;
				if (cmp_a_first) begin
					place_node = ch_node_q;
				end
			end
			default: ;
		endcase
	end

	// Operand selection for the one comparator.
	always_comb begin
		cmp_a_key  = ch_key_q;
		cmp_a_node = ch_node_q;
		cmp_b_key  = key_q;
		cmp_b_node = mov_q;
		case (state_q)
			S_UP2: begin
				cmp_a_key  = key_q;
				cmp_a_node = mov_q;
				cmp_b_key  = key_rd_a_q;
				cmp_b_node = par_q;
			end
			S_DN2: begin
				cmp_a_key  = key_rd_b_q;
				cmp_a_node = rch_q;
				cmp_b_key  = key_rd_a_q;
				cmp_b_node = lch_q;
			end
			default: ;
		endcase
	end

	imh_cmp #(
		.KEY_W  (KEY_BITS),
		.NODE_W (SLOT_W)
	) u_cmp (
		.a_key   (cmp_a_key),
		.a_node  (cmp_a_node),
		.b_key   (cmp_b_key),
		.b_node  (cmp_b_node),
		.a_first (cmp_a_first)
	);

	// Memories: one write per table per cycle, registered reads. Key reads always
	// follow the node numbers just read from the slot table.
	always_ff @(posedge clk) begin
		if (place_we) begin
			hs_mem[place_slot]  <= place_node;
			son_mem[place_node] <= place_slot;
		end
		if (key_we) begin
			key_mem[node_q] <= key_q;
		end
		hs_rd_a_q  <= hs_mem[hs_ra_a];
		hs_rd_b_q  <= hs_mem[hs_ra_b];
		son_rd_q   <= son_mem[node_q];
		key_rd_a_q <= key_mem[hs_rd_a_q];
		key_rd_b_q <= key_mem[hs_rd_b_q];
	end

	// Sequencer, heap size and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			size_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {OUT_PAD_W'(0), COUNT_W'(size_q), status_q, pop_key_q, pop_node_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						act_q      <= action_t'(in_action);
						node_q     <= SLOT_W'(in_node);
						key_q      <= KEY_BITS'(in_key);
						status_q   <= ST_OK;
						pop_node_q <= '0;
						pop_key_q  <= '0;
						case (action_t'(in_action))
							ACT_PUSH: begin
								if ((32'(size_q) >= 32'(MAX_NODES)) || in_node_oob) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_CHK0;
								end
							end
							ACT_POP: begin
								if (size_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_POP0;
								end
							end
							ACT_DEC_KEY: begin
								if (in_node_oob) begin
									status_q <= ST_NOT_QUEUED;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_CHK0;
								end
							end
							default: begin
								size_q  <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CHK0: state_q <= S_CHK1;
				S_CHK1: begin
					pos_q   <= son_rd_q;
					state_q <= S_CHK2;
				end
				S_CHK2: begin
					mov_q <= node_q;
					if (act_q == ACT_PUSH) begin
						if (chk_queued) begin
							status_q <= ST_QUEUED;
							state_q  <= S_DONE;
						end else begin
							pos_q   <= SLOT_W'(size_q);
							size_q  <= size_q + SIZE_W'(1);
							state_q <= S_UP0;
						end
					end else begin
						if (chk_queued) begin
							state_q <= S_UP0;
						end else begin
							status_q <= ST_NOT_QUEUED;
							state_q  <= S_DONE;
						end
					end
				end
				S_UP0: state_q <= (pos_q == '0) ? S_DONE : S_UP1;
				S_UP1: begin
					par_q   <= hs_rd_a_q;
					state_q <= S_UP2;
				end
				S_UP2: begin
					if (cmp_a_first) begin
						pos_q   <= parent_slot;
						state_q <= (parent_slot == '0) ? S_UP0 : S_UP1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_POP0: state_q <= S_POP1;
				S_POP1: begin
					pop_node_q <= NODE_FIELD_W'(hs_rd_a_q);
					mov_q      <= hs_rd_b_q;
					size_q     <= size_q - SIZE_W'(1);
					state_q    <= S_POP2;
				end
				S_POP2: begin
					pop_key_q <= KEY_FIELD_W'(key_rd_a_q);
					key_q     <= key_rd_b_q;
					pos_q     <= '0;
					state_q   <= (size_q == '0) ? S_DONE : S_DN0;
				end
				S_DN0: state_q <= l_ok ? S_DN1 : S_DONE;
				S_DN1: begin
					lch_q   <= hs_rd_a_q;
					rch_q   <= hs_rd_b_q;
					state_q <= S_DN2;
				end
				S_DN2: begin
					if (r_ok && cmp_a_first) begin
						ch_node_q <= rch_q;
						ch_key_q  <= key_rd_b_q;
						ch_slot_q <= SLOT_W'(right_idx);
					end else begin
						ch_node_q <= lch_q;
						ch_key_q  <= key_rd_a_q;
						ch_slot_q <= SLOT_W'(left_idx);
					end
					state_q <= S_DN3;
				end
				S_DN3: begin
					if (cmp_a_first) begin
						pos_q   <= ch_slot_q;
						state_q <= S_DN0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`IMH_ASSERT_SAME(a_size_bound, 1'b1, 32'(size_q) <= 32'(MAX_NODES), "heap size above capacity")
	`IMH_ASSERT_NEXT(a_accept_busy, in_accept, !s_tready, "ready right after an accepted word")
	`IMH_ASSERT_NEXT(a_done_waits, (state_q == S_DONE) && m_tvalid_q && !m_tready, (state_q == S_DONE) && $stable(m_tdata_q), "pending result overwritten")
	`IMH_ASSERT_SAME(a_err_no_pop, (state_q == S_DONE) && (status_q != ST_OK), (pop_node_q == '0) && (pop_key_q == '0), "pop fields set on an error")
	`IMH_ASSERT_NEXT(a_rise_climbs, (state_q == S_UP2) && cmp_a_first, pos_q < $past(pos_q), "sift up did not move toward the root")

endmodule

// File: sim/imh_heap_checker.sv
// Monitor that mirrors the indexed min-heap from accepted words and checks every result word.
`timescale 1ns / 1ps

module imh_heap_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	// action[1:0], node[9:2], key[41:10], zero pad above
	input  logic [imh_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// popped_node[7:0], popped_key[39:8], status[42:40], queued_count[51:43], zero pad above
	input  logic [imh_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);
	import imh_pkg::*;

	localparam int HEAP_CAP = 256;

	typedef struct {
		logic [NODE_FIELD_W-1:0] popped_node;
		logic [KEY_FIELD_W-1:0]  popped_key;
		status_t                 status;
		logic [COUNT_W-1:0]      queued_count;
	} heap_result_t;

	// Mirror of the heap: node held by each slot, slot of each node, membership and keys.
	logic [7:0]  slot_node [HEAP_CAP];
	logic [7:0]  node_slot [HEAP_CAP];
	bit          node_in_heap [HEAP_CAP];
	logic [31:0] node_key [HEAP_CAP];
	int          heap_count;

	heap_result_t expected_results [$];
	int fails;
	int checks;

	initial begin
		heap_count = 0;
		fails = 0;
		checks = 0;
		for (int i = 0; i < HEAP_CAP; i++) begin
			node_in_heap[i] = 1'b0;
		end
	end

	// Smaller key first; on equal keys the smaller node number wins.
	function automatic bit ranks_first(logic [7:0] a, logic [7:0] b);
		if (node_key[a] != node_key[b]) begin
			return node_key[a] < node_key[b];
		end
		return a < b;
	endfunction

	function automatic void swap_slots(int sa, int sb);
		logic [7:0] na;
		logic [7:0] nb;
		na = slot_node[sa];
		nb = slot_node[sb];
		slot_node[sa] = nb;
		slot_node[sb] = na;
		node_slot[na] = sb[7:0];
		node_slot[nb] = sa[7:0];
	endfunction

	function automatic void climb(int s);
		int up;
		while (s > 0 && s < heap_count) begin
			up = (s - 1) / 2;
			if (!ranks_first(slot_node[s], slot_node[up])) begin
				break;
			end
			swap_slots(s, up);
			s = up;
		end
	endfunction

	function automatic void settle(int s);
		int best;
		int lc;
		int rc;
		while (1) begin
			best = s;
			lc = 2 * s + 1;
			rc = 2 * s + 2;
			if (lc < heap_count && ranks_first(slot_node[lc], slot_node[best])) begin
				best = lc;
			end
			if (rc < heap_count && ranks_first(slot_node[rc], slot_node[best])) begin
				best = rc;
			end
			if (best == s) begin
				break;
			end
			swap_slots(s, best);
			s = best;
		end
	endfunction

	// Applies one action to the mirror and returns the result word it must produce.
	function automatic heap_result_t heap_apply(action_t act, logic [7:0] nd, logic [31:0] k);
		heap_result_t r;
		logic [7:0] top;
		logic [7:0] last;
		r.popped_node = '0;
		r.popped_key = '0;
		r.status = ST_OK;
		case (act)
			ACT_PUSH: begin
				if (heap_count >= HEAP_CAP) begin
					r.status = ST_FULL;
				end else if (node_in_heap[nd]) begin
					r.status = ST_QUEUED;
				end else begin
					node_key[nd] = k;
					slot_node[heap_count] = nd;
					node_slot[nd] = heap_count[7:0];
					node_in_heap[nd] = 1'b1;
					heap_count++;
					climb(heap_count - 1);
				end
			end
			ACT_POP: begin
				if (heap_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					top = slot_node[0];
					r.popped_node = top;
					r.popped_key = node_key[top];
					node_in_heap[top] = 1'b0;
					heap_count--;
					if (heap_count > 0) begin
						last = slot_node[heap_count];
						slot_node[0] = last;
						node_slot[last] = 8'd0;
						settle(0);
					end
				end
			end
			ACT_DEC_KEY: begin
				if (!node_in_heap[nd]) begin
					r.status = ST_NOT_QUEUED;
				end else begin
					// The key is overwritten even when it grows; the node only moves up.
					node_key[nd] = k;
					climb(int'(node_slot[nd]));
				end
			end
			default: begin
				heap_count = 0;
				for (int i = 0; i < HEAP_CAP; i++) begin
					node_in_heap[i] = 1'b0;
				end
			end
		endcase
		r.queued_count = heap_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : monitor
		heap_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word %h arrived with nothing expected", m_tdata);
					fails++;
				end else begin
					want = expected_results.pop_front();
					check_field("popped_node", want.popped_node, m_tdata[7:0]);
					check_field("popped_key", want.popped_key, m_tdata[39:8]);
					check_field("status", want.status, m_tdata[42:40]);
					check_field("queued_count", want.queued_count, m_tdata[51:43]);
					check_field("pad", 0, m_tdata[OUT_DATA_W-1:52]);
					checks++;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(heap_apply(action_t'(s_tdata[1:0]), s_tdata[9:2],
					s_tdata[41:10]));
			end
		end
		fail_count <= fails;
		pending <= expected_results.size();
		checked <= checks;
	end

endmodule

// File: sim/tb_indexed_min_heap_decrease_key.sv
// Testbench top for the indexed min-heap: clock, reset, word stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_indexed_min_heap_decrease_key;
	import imh_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tvalid;
	logic                  m_tready;

	int fail_count;
	int pending;
	int checked;

	// Handshake mix of the current phase, in percent of cycles.
	int sender_idle_pct;
	int receiver_stall_pct;
	// The stimulus bumps this to ask the output side for one long hold-off.
	int hold_requests;
	int words_sent;

	indexed_min_heap_decrease_key uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	imh_heap_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output side. Each cycle it either accepts or stalls at the phase's rate. When a
	// hold-off has been requested it keeps tready low for a fixed stretch, counting
	// the cycles itself, so the block backs up and has to drop s_tready.
	initial begin : receiver
		int holds_served;
		int held;
		holds_served = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				m_tready <= 1'b0;
				for (held = 0; held < 400; held++) begin
					@(posedge clk);
				end
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Offers one word and returns at the edge where it was taken. Idle cycles are
	// inserted before the word at the phase's rate; without a gap tvalid simply stays
	// high and only the data changes, so a back-to-back word never toggles tvalid.
	task automatic send_word(action_t act, logic [7:0] nd, logic [31:0] k);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {{(IN_DATA_W - 42){1'b0}}, k, nd, act};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// Stops offering and waits until every outstanding result word has been checked.
	// The first edge lets the checker count the word that was just accepted.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Keys drawn from a few bands: tiny values give many ties, the top band hits the
	// upper bits, one band stays below 4096, and the rest spreads over the whole range.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(3))
			0: return 32'($urandom_range(15));
			1: return 32'hFFFF_FFFF - 32'($urandom_range(15));
			2: return 32'($urandom_range(4095));
			default: return $urandom();
		endcase
	endfunction

	// Random mix of actions. Nodes mostly come from a small pool so that pushes hit
	// queued nodes and decrease-keys find their target; clears are kept rare so the
	// heap gets a few levels deep between them.
	task automatic random_words(int count, int push_wt, int node_span);
		action_t act;
		logic [7:0] nd;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < push_wt) begin
				act = ACT_PUSH;
			end else if (pick >= 98) begin
				act = ACT_CLEAR;
			end else if (pick[0]) begin
				act = ACT_POP;
			end else begin
				act = ACT_DEC_KEY;
			end
			if ($urandom_range(3) == 0) begin
				nd = 8'($urandom_range(255));
			end else begin
				nd = 8'($urandom_range(node_span));
			end
			send_word(act, nd, pick_key());
		end
	endtask

	// Empties the heap, pushes all 256 nodes in shuffled order, then tries two more
	// pushes that must see a full heap (one of them names a queued node, and full
	// takes precedence), moves a few keys down and pops everything plus one more.
	task automatic fill_and_empty_heap();
		logic [7:0] order [256];
		logic [7:0] swap_tmp;
		int j;
		for (int i = 0; i < 256; i++) begin
			order[i] = 8'(i);
		end
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(i);
			swap_tmp = order[i];
			order[i] = order[j];
			order[j] = swap_tmp;
		end
		send_word(ACT_CLEAR, 8'($urandom_range(255)), $urandom());
		for (int i = 0; i < 256; i++) begin
			send_word(ACT_PUSH, order[i], pick_key());
		end
		send_word(ACT_PUSH, order[0], 32'd0);
		send_word(ACT_PUSH, 8'($urandom_range(255)), $urandom());
		for (int i = 0; i < 24; i++) begin
			send_word(ACT_DEC_KEY, 8'($urandom_range(255)), 32'($urandom_range(40)));
		end
		for (int i = 0; i < 257; i++) begin
			send_word(ACT_POP, 8'($urandom_range(255)), $urandom());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_requests = 0;
		words_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with both sides at full rate. Covers pop and decrease-key on
		// an empty heap, a repeated push, key ties broken by node number, a decrease-key
		// that raises the key, one that keeps it, clear followed by reuse of the nodes,
		// and the extreme node numbers and keys.
		send_word(ACT_POP, 8'd0, 32'd0);
		send_word(ACT_DEC_KEY, 8'd9, 32'd5);
		send_word(ACT_PUSH, 8'd0, 32'd0);
		send_word(ACT_PUSH, 8'd255, 32'hFFFF_FFFF);
		send_word(ACT_PUSH, 8'd0, 32'd7);
		send_word(ACT_PUSH, 8'd128, 32'hFFFF_FFFF);
		send_word(ACT_PUSH, 8'd85, 32'h5555_5555);
		send_word(ACT_PUSH, 8'd170, 32'hAAAA_AAAA);
		send_word(ACT_DEC_KEY, 8'd255, 32'd0);
		send_word(ACT_DEC_KEY, 8'd170, 32'hFFFF_FFFF);
		send_word(ACT_DEC_KEY, 8'd85, 32'h5555_5555);
		send_word(ACT_POP, 8'd255, 32'hFFFF_FFFF);
		send_word(ACT_POP, 8'd0, 32'd0);
		send_word(ACT_POP, 8'd0, 32'd0);
		send_word(ACT_PUSH, 8'd1, 32'd1);
		send_word(ACT_CLEAR, 8'd255, 32'hFFFF_FFFF);
		send_word(ACT_POP, 8'd0, 32'd0);
		send_word(ACT_DEC_KEY, 8'd128, 32'd0);
		send_word(ACT_PUSH, 8'd128, 32'd3);
		send_word(ACT_PUSH, 8'd0, 32'd3);
		send_word(ACT_POP, 8'd0, 32'd0);
		send_word(ACT_POP, 8'd0, 32'd0);
		send_word(ACT_POP, 8'd0, 32'd0);
		drain();

		// Random traffic, first with no idling at all.
		random_words(250, 50, 63);

		// Sender idle in about half the cycles.
		sender_idle_pct = 49;
		random_words(250, 45, 255);

		// Long output hold-off while words keep coming back to back, so the block
		// fills up and stalls its input; afterwards the sender waits for a full drain.
		sender_idle_pct = 0;
		hold_requests <= hold_requests + 1;
		random_words(40, 60, 31);
		drain();

		// Receiver stalling in about half the cycles.
		receiver_stall_pct = 49;
		random_words(250, 55, 31);
		drain();

		// Both sides irregular, including a pass through a completely full heap.
		sender_idle_pct = 33;
		receiver_stall_pct = 33;
		fill_and_empty_heap();
		random_words(250, 50, 127);

		drain();
		repeat (60) @(posedge clk);

		$display("Summary: %0d words offered and accepted, %0d result words checked.",
			words_sent, checked);
		$display("Covered all actions and status codes on empty, partial and full heaps, "
			, "four handshake mixes and a long output stall.");
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Safety net: several times the slowest expected run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d result words still outstanding.", pending);
		$display("Regression FAIL");
		$finish;
	end

endmodule
